FILE: sv/frcf_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the record framer.
// Used by frcf_ctrl, frcf_out and flash_record_framer_crc16.
package frcf_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // Up to three output words produced by one input word, word 0 goes out first
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            rec_end;
    } frcf_burst_t;

    // CRC-16, MSB first, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/flash_record_framer_crc16.sv
// Flash record framer: record id, payload bytes, complemented CRC-16 per record.
// Latency: the first output word of an input word is valid the cycle after it is accepted.
// Throughput: one input word per cycle mid-record while m_axis_tready is high; the
// first and last payload words each load three output words, so a record of N payload
// bytes gives N + 4 output words. Reset (aresetn low, synchronous) empties the
// output register and restarts at the first byte of a record with CRC 0xFFFF.
module flash_record_framer_crc16 #(
    parameter int PAYLOAD_BYTES = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] record_id, [23:16] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // record_end
);
    import frcf_pkg::*;

    frcf_burst_t burst;
    logic        room;
    logic        accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    // Position, CRC and burst building
    frcf_ctrl #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .record_id  (s_axis_tdata[15:0]),
        .data_byte  (s_axis_tdata[23:16]),
        .burst      (burst)
    );

    // Output register and serializer
    frcf_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .burst         (burst),
        .room          (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: sv/frcf_ctrl.sv
// Record position and running CRC; turns one payload word into its output burst.
// Depends on frcf_pkg.
module frcf_ctrl #(
    parameter int PAYLOAD_BYTES = 60
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [15:0]         record_id,
    input  logic [7:0]          data_byte,
    output frcf_pkg::frcf_burst_t burst
);
    import frcf_pkg::*;

    localparam int RecLen = (PAYLOAD_BYTES < 2) ? 2 : ((PAYLOAD_BYTES > 63) ? 63 : PAYLOAD_BYTES);
    localparam logic [6:0] REC_LEN = 7'(RecLen);

    logic [5:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        first;
    logic        done;
    logic [6:0]  pos_inc;
    logic [15:0] crc_start;
    logic [15:0] crc_data;
    logic [15:0] crc_final;

    // Fold id bytes on the first word, then the payload byte
    always_comb begin
        first     = (pos_reg == 6'd0);
        crc_start = first ? crc_byte(crc_byte(CRC_INIT, record_id[7:0]), record_id[15:8])
                          : crc_reg;
        crc_data  = crc_byte(crc_start, data_byte);
        crc_final = crc_data ^ CRC_XOROUT;
        pos_inc   = {1'b0, pos_reg} + 7'd1;
        done      = (pos_inc >= REC_LEN);
    end

    // Build the burst for this word
    always_comb begin
        burst = '0;
        if (first) begin
            burst.bytes   = {data_byte, record_id[15:8], record_id[7:0]};
            burst.count   = 2'd3;
            burst.rec_end = 1'b0;
        end else if (done) begin
            burst.bytes   = {crc_final[15:8], crc_final[7:0], data_byte};
            burst.count   = 2'd3;
            burst.rec_end = 1'b1;
        end else begin
            burst.bytes   = {8'h00, 8'h00, data_byte};
            burst.count   = 2'd1;
            burst.rec_end = 1'b0;
        end
    end

    // Advance position and CRC, restart after the last payload byte
    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (accept) begin
            pos_next = done ? 6'd0 : pos_inc[5:0];
            crc_next = done ? CRC_INIT : crc_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, pos_reg} < REC_LEN)
        else $error("record position beyond record length");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done |=> pos_reg == 6'd0)
        else $error("position not cleared after last payload byte");

    a_first_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && first |=> pos_reg == 6'd1)
        else $error("position not advanced after first payload byte");

endmodule

FILE: sv/frcf_out.sv
// Output register bank that serializes a burst of one to three words onto the stream.
// Depends on frcf_pkg.
module frcf_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  frcf_pkg::frcf_burst_t burst,
    output logic                room,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
    output logic                m_axis_tlast   // record_end
);
    import frcf_pkg::*;

    logic [2:0][7:0] bytes_reg;
    logic [1:0]      cnt_reg, cnt_next;
    logic [1:0]      idx_reg, idx_next;
    logic            end_reg;
    logic            take;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = bytes_reg[idx_reg];
    assign m_axis_tlast  = end_reg && (cnt_reg == 2'd1);
    assign take          = m_axis_tvalid && m_axis_tready;
    // Free when empty, or once the last held word leaves in this cycle
    assign room          = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);

    // Load a new burst or step through the held one
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = burst.count;
            idx_next = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
            end_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (load) begin
                end_reg <= burst.rec_end;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && take))
        else $error("burst loaded over undelivered words");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_axis_tvalid)
        else $error("loaded burst not presented");

    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tlast |-> idx_reg == 2'd2)
        else $error("record end marked on a word other than the final CRC byte");

endmodule
